/* hw/rtl/gbn_pkg.sv */
// Shared constants, codes and types for the go-back-n sender window.
// Used by the top level; the generic window RAM stands alone.
package gbn_pkg;

    localparam int WIN_DEPTH = 8;
    localparam int SLOT_W    = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int SEQ_W     = 16;
    localparam int PAY_W     = 64;
    localparam int TICK_W    = 16;
    localparam int LIMIT_W   = 4;
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int ENTRY_W   = PAY_W + 1;

    localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    localparam logic [STAT_W-1:0] ST_SENT        = 3'd0;
    localparam logic [STAT_W-1:0] ST_RESENT      = 3'd1;
    localparam logic [STAT_W-1:0] ST_WIN_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ACK_ADV     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ACK_IGNORED = 3'd4;
    localparam logic [STAT_W-1:0] ST_AFTER_FINAL = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;

    localparam logic [TICK_W-1:0]  TIMEOUT_RST = 16'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(WIN_DEPTH);
    localparam logic [SEQ_W-1:0]   SEQ_RST     = 16'd1;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEQ_W-1:0]  seq_no;
        logic [PAY_W-1:0]  payload;
        logic              final_mark;
        logic              last;
        logic [CNT_W-1:0]  outstanding;
        logic              done;
    } t_result;

    // Ring slot plus an offset of at most WIN_DEPTH, wrapped once.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, s} + {1'b0, k};
        if (sum >= (CNT_W + 1)'(WIN_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(WIN_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

/* hw/rtl/gbn_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/go_back_n_sender_window_core.sv */
// Go-back-n sender window: sequencing, acknowledgement and timeout resend.
// A send or ack result is registered in the result queue before it is visible.
// Throughput: one item per cycle for sends, acks and ticks that do not time out, unless the queue is full.
// A timeout resends n packets through the window RAM's single read port, one per cycle while
// the result queue has room; input stalls until the last resend is read into the queue.
// Reset is synchronous, active low; no clearing pass, window RAM undefined until written.
module go_back_n_sender_window_core
    import gbn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [PAY_W-1:0]     i_payload,
    input  logic                 i_is_final,
    input  logic                 i_ack_flag,
    input  logic [SEQ_W-1:0]     i_ack_seq,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [SEQ_W-1:0]     o_seq_no,
    output logic [PAY_W-1:0]     o_out_payload,
    output logic                 o_out_final,
    output logic                 o_last,
    output logic [CNT_W-1:0]     o_outstanding,
    output logic                 o_done_res,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RESEND = 1'b1;

    logic                r_state, n_state;
    logic [SEQ_W-1:0]    r_base_seq, n_base_seq;
    logic [SEQ_W-1:0]    r_next_seq, n_next_seq;
    logic [SLOT_W-1:0]   r_base_slot, n_base_slot;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic                r_final_sent, n_final_sent;
    logic [TICK_W-1:0]   r_timeout;
    logic [LIMIT_W-1:0]  r_limit;
    logic [CNT_W-1:0]    r_rs_idx, n_rs_idx;
    logic                r_rd_pend, n_rd_pend;
    logic [SEQ_W-1:0]    r_rd_seq, n_rd_seq;
    logic                r_rd_last, n_rd_last;

    // two-entry result queue
    t_result             r_fifo [2];
    logic                r_wr_ptr, r_rd_ptr;
    logic [1:0]          r_cnt;

    logic [SEQ_W-1:0]    w_diff;
    logic [CNT_W-1:0]    w_o;
    logic                w_pop;
    logic                w_accept_ok;
    logic                w_acc;
    logic [2:0]          w_occ;
    logic                w_issue;
    logic [LIMIT_W-1:0]  w_lim;
    logic [TICK_W-1:0]   w_tmo;
    logic [TICK_W-1:0]   w_tick_inc;
    logic [SEQ_W-1:0]    w_ack_d;
    logic [SEQ_W-1:0]    w_diff_after;
    logic [CNT_W-1:0]    w_o_after;
    logic                w_in_push;
    t_result             w_in_res;
    t_result             w_rs_res;
    t_result             w_push_data;
    logic                w_push;
    logic                w_wr_en;
    logic [SLOT_W-1:0]   w_wr_slot;
    logic [SLOT_W-1:0]   w_rd_slot;
    logic [ENTRY_W-1:0]  w_rd_data;
    logic [CNT_W-1:0]    w_idx_inc;

    assign w_diff      = r_next_seq - r_base_seq;
    assign w_o         = w_diff[CNT_W-1:0];
    assign o_out_valid = (r_cnt != 2'd0);
    assign w_pop       = o_out_valid && !i_out_stall;

    // An input is accepted only when idle, with one free queue entry and no RAM read still in flight.
    assign w_accept_ok = (r_state == S_IDLE) && !r_rd_pend && ((r_cnt != 2'd2) || w_pop);
    assign o_in_stall  = !w_accept_ok;
    assign w_acc       = i_in_valid && w_accept_ok;
    assign o_cfg_ready = 1'b1;

    // A resend read is issued only if its data will find room in the queue in the cycle after.
    assign w_occ   = {1'b0, r_cnt} + {2'b00, r_rd_pend};
    assign w_issue = (r_state == S_RESEND) && ((w_occ < 3'd2) || ((w_occ == 3'd2) && w_pop));

    assign w_lim = (r_limit == '0) ? LIMIT_W'(1) :
                   (r_limit > LIMIT_W'(WIN_DEPTH)) ? LIMIT_W'(WIN_DEPTH) : r_limit;
    assign w_tmo      = (r_timeout == '0) ? TICK_W'(1) : r_timeout;
    assign w_tick_inc = r_tick + TICK_W'(1);
    assign w_ack_d    = i_ack_seq - r_base_seq;
    assign w_wr_slot  = slot_add(r_base_slot, w_o);
    assign w_rd_slot  = slot_add(r_base_slot, r_rs_idx);
    assign w_idx_inc  = r_rs_idx + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_base_seq   = r_base_seq;
        n_next_seq   = r_next_seq;
        n_base_slot  = r_base_slot;
        n_tick       = r_tick;
        n_final_sent = r_final_sent;
        n_rs_idx     = r_rs_idx;
        n_rd_pend    = 1'b0;
        n_rd_seq     = r_rd_seq;
        n_rd_last    = r_rd_last;
        w_in_push    = 1'b0;
        w_wr_en      = 1'b0;
        w_in_res     = '0;
        w_in_res.last = 1'b1;

        if (w_acc) begin
            case (i_mode)
                MODE_SEND: begin
                    w_in_push = 1'b1;
                    if (r_final_sent) begin
                        w_in_res.status = ST_AFTER_FINAL;
                    end else if (w_o >= CNT_W'(w_lim)) begin
                        w_in_res.status = ST_WIN_FULL;
                    end else begin
                        w_wr_en             = 1'b1;
                        n_next_seq          = r_next_seq + SEQ_W'(1);
                        n_final_sent        = r_final_sent | i_is_final;
                        w_in_res.status     = ST_SENT;
                        w_in_res.seq_no     = r_next_seq;
                        w_in_res.payload    = i_payload;
                        w_in_res.final_mark = i_is_final;
                    end
                end
                MODE_ACK: begin
                    w_in_push = 1'b1;
                    if (i_ack_flag && (w_ack_d < {{(SEQ_W - CNT_W){1'b0}}, w_o})) begin
                        n_base_seq      = i_ack_seq + SEQ_W'(1);
                        n_base_slot     = slot_add(r_base_slot,
                                                   w_ack_d[CNT_W-1:0] + CNT_W'(1));
                        n_tick          = '0;
                        w_in_res.status = ST_ACK_ADV;
                    end else begin
                        w_in_res.status = ST_ACK_IGNORED;
                    end
                end
                MODE_TICK: begin
                    if (w_o == '0) begin
                        n_tick = '0;
                    end else if (w_tick_inc < w_tmo) begin
                        n_tick = w_tick_inc;
                    end else begin
                        n_tick   = '0;
                        n_state  = S_RESEND;
                        n_rs_idx = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_issue) begin
            n_rd_pend = 1'b1;
            n_rd_seq  = r_base_seq + {{(SEQ_W - CNT_W){1'b0}}, r_rs_idx};
            n_rd_last = (w_idx_inc == w_o);
            n_rs_idx  = w_idx_inc;
            if (w_idx_inc == w_o) begin
                n_state = S_IDLE;
            end
        end

        // Count and done flag reflect the state after this item.
        w_diff_after         = n_next_seq - n_base_seq;
        w_o_after            = w_diff_after[CNT_W-1:0];
        w_in_res.outstanding = w_o_after;
        w_in_res.done        = n_final_sent && (w_o_after == '0);
    end

    gbn_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(WIN_DEPTH)
    ) u_window_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_slot),
        .i_wr_data({i_is_final, i_payload}),
        .i_rd_en  (w_issue),
        .i_rd_addr(w_rd_slot),
        .o_rd_data(w_rd_data)
    );

    always_comb begin
        w_rs_res             = '0;
        w_rs_res.status      = ST_RESENT;
        w_rs_res.seq_no      = r_rd_seq;
        w_rs_res.payload     = w_rd_data[PAY_W-1:0];
        w_rs_res.final_mark  = w_rd_data[PAY_W];
        w_rs_res.last        = r_rd_last;
        w_rs_res.outstanding = w_o;
        w_rs_res.done        = r_final_sent && (w_o == '0);
    end

    // Input results and resend data never reach the queue in the same cycle.
    assign w_push      = w_in_push || r_rd_pend;
    assign w_push_data = r_rd_pend ? w_rs_res : w_in_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base_seq   <= SEQ_RST;
            r_next_seq   <= SEQ_RST;
            r_base_slot  <= '0;
            r_tick       <= '0;
            r_final_sent <= 1'b0;
            r_timeout    <= TIMEOUT_RST;
            r_limit      <= LIMIT_RST;
            r_rs_idx     <= '0;
            r_rd_pend    <= 1'b0;
            r_wr_ptr     <= 1'b0;
            r_rd_ptr     <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            r_state      <= n_state;
            r_base_seq   <= n_base_seq;
            r_next_seq   <= n_next_seq;
            r_base_slot  <= n_base_slot;
            r_tick       <= n_tick;
            r_final_sent <= n_final_sent;
            r_rs_idx     <= n_rs_idx;
            r_rd_pend    <= n_rd_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[TICK_W-1:0];
                    CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_seq  <= n_rd_seq;
        r_rd_last <= n_rd_last;
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_push_data;
        end
    end

    assign o_status      = r_fifo[r_rd_ptr].status;
    assign o_seq_no      = r_fifo[r_rd_ptr].seq_no;
    assign o_out_payload = r_fifo[r_rd_ptr].payload;
    assign o_out_final   = r_fifo[r_rd_ptr].final_mark;
    assign o_last        = r_fifo[r_rd_ptr].last;
    assign o_outstanding = r_fifo[r_rd_ptr].outstanding;
    assign o_done_res    = r_fifo[r_rd_ptr].done;

endmodule
